// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Implication form: when ante holds, cons holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/tkss_pkg.sv
// ---------------------------------------------------------------------------
// tkss_pkg
// Types, constants and pixel helpers for the texture key/scale/swizzle block.
// ---------------------------------------------------------------------------
package tkss_pkg;

   localparam int SIZE_W     = 9;
   localparam int STEP_W     = 25;
   localparam int KEY_W      = 24;
   localparam int MODE_W     = 3;
   localparam int PIX_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam int ACC_FRAC   = 16;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
   localparam logic [STEP_W-1:0] STEP_RESET = 25'h001_0000;
   localparam logic [STEP_W-1:0] ACC_MAX    = '1;
   localparam logic [PIX_W-1:0]  ALPHA_OPAQUE = 32'hff00_0000;
   localparam logic signed [9:0] KEY_TOL    = 10'sd2;

   // mode register bits
   localparam int MODE_KEY_EN = 0;
   localparam int MODE_BGRA   = 1;
   localparam int MODE_BIG    = 2;

   // csr register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_WIDTH  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_TARGET_WIDTH  = 3'd2,
      REG_TARGET_HEIGHT = 3'd3,
      REG_STEP_X        = 3'd4,
      REG_STEP_Y        = 3'd5,
      REG_KEY_RGB       = 3'd6,
      REG_MODE          = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_READ,
      ST_DONE
   } state_type;

   function automatic logic near_key(logic [7:0] chan, logic [7:0] key);
      logic signed [9:0] diff;
      diff = signed'({2'b00, chan}) - signed'({2'b00, key});
      return (diff >= -KEY_TOL) && (diff <= KEY_TOL);
   endfunction

   function automatic logic [PIX_W-1:0] key_pixel(logic [PIX_W-1:0] pix,
                                                  logic [KEY_W-1:0] key,
                                                  logic             enable);
      logic hit;
      hit = near_key(pix[7:0], key[7:0]) && near_key(pix[15:8], key[15:8]) &&
            near_key(pix[23:16], key[23:16]);
      if (!enable) begin
         return pix;
      end else if (hit) begin
         return '0;
      end
      return pix | ALPHA_OPAQUE;
   endfunction

   function automatic logic [PIX_W-1:0] swizzle(logic [PIX_W-1:0] pix,
                                                logic bgra, logic big);
      logic [PIX_W-1:0] res;
      unique case ({bgra, big})
         2'b10: res = pix;
         2'b11: res = {pix[7:0], pix[15:8], pix[23:16], pix[31:24]};
         2'b01: res = {pix[23:0], pix[31:24]};
         default: res = {pix[31:24], pix[7:0], pix[15:8], pix[23:16]};
      endcase
      return res;
   endfunction

   function automatic logic [STEP_W-1:0] sat_add(logic [STEP_W-1:0] a,
                                                 logic [STEP_W-1:0] b);
      logic [STEP_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[STEP_W] ? ACC_MAX : sum[STEP_W-1:0];
   endfunction

endpackage

// File: rtl/texture_key_scale_swizzle.sv
// ---------------------------------------------------------------------------
// texture_key_scale_swizzle
// Nearest-neighbor image scaler with color key, vertical flip and swizzle.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: tuser[0] = 0 loads the next source pixel (tdata, ARGB32)
//   into the frame store in raster order, keyed on the way in when mode
//   bit 0 is set; tuser[0] = 1 requests the next destination pixel.
//   rsp channel: one transaction per emit request, tdata = swizzled pixel,
//   tlast = last pixel of a destination row, tuser[0] = last of the frame.
//   csr channel: register writes (index/data), always ready; write only
//   while no emit is in flight.
// Sequence: a load is written into the frame store when it is accepted. An
//   emit passes the address multiply, the registered frame store read and
//   the swizzle on its way into the output register; the next request is
//   taken once the result is loaded there, with one item in flight at a time.
// Reset: synchronous, active high; registers go to their defaults, load
//   and emit positions restart. Frame store contents are not cleared.
// Stall: the result sits in the output register; a finished emit waits in
//   its last state until that register frees up, req_tready stays low.
// ---------------------------------------------------------------------------
module texture_key_scale_swizzle #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tkss_pkg::PIX_W-1:0]    req_tdata,   // [31:0] source_pixel
   input  logic [0:0]                    req_tuser,   // [0] cmd
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tkss_pkg::PIX_W-1:0]    rsp_tdata,   // [31:0] out_pixel
   output logic                          rsp_tlast,   // row_end
   output logic [0:0]                    rsp_tuser,   // [0] frame_end
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tkss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tkss_pkg::CSR_DATA_W-1:0] csr_data
);
   import tkss_pkg::*;

   `include "assert_macros.svh"

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SWW   = $clog2(MAX_WIDTH + 1);
   localparam int SHW   = $clog2(MAX_HEIGHT + 1);
   localparam int IW    = STEP_W - ACC_FRAC;   // integer part of accumulator

   // size registers are used clamped to 1..MAX
   function automatic logic [SWW-1:0] clamp_w(logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return SWW'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         return SWW'(MAX_WIDTH);
      end
      return SWW'(v);
   endfunction

   function automatic logic [SHW-1:0] clamp_h(logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return SHW'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         return SHW'(MAX_HEIGHT);
      end
      return SHW'(v);
   endfunction

   // config registers
   logic [SIZE_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [MODE_W-1:0] mode_ff;

   // load and emit position
   logic [AW-1:0]     ld_ptr_ff;
   logic [CW-1:0]     ld_col_ff;
   logic [RW-1:0]     ld_row_ff;
   logic [STEP_W-1:0] acc_x_ff, acc_y_ff;
   logic [CW-1:0]     dst_col_ff;
   logic [RW-1:0]     dst_row_ff;

   // emit pipeline payload
   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic              rend_ff, fend_ff;
   logic [AW-1:0]     addr_ff;
   logic [PIX_W-1:0]  rd_data_ff;

   // output register
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff, rsp_frame_ff;

   state_type state_ff, state_in;

   // frame store
   logic [PIX_W-1:0] frame_mem [DEPTH];

   logic [SWW-1:0] sw;
   logic [SHW-1:0] sh;
   logic [SWW-1:0] tw;
   logic [SHW-1:0] th;
   logic [CW-1:0]  sw_m1, tw_m1;
   logic [RW-1:0]  sh_m1, th_m1;
   logic [IW-1:0]  x_int, y_int;
   logic [CW-1:0]  col_sel;
   logic [RW-1:0]  up_sel;
   logic           rend, fend;
   logic           req_fire, load_fire, emit_fire, csr_fire;
   logic           out_free, out_load;
   logic [PIX_W-1:0] load_pix;

   always_comb begin
      sw    = clamp_w(src_w_ff);
      sh    = clamp_h(src_h_ff);
      tw    = clamp_w(tgt_w_ff);
      th    = clamp_h(tgt_h_ff);
      sw_m1 = CW'(sw - SWW'(1));
      sh_m1 = RW'(sh - SHW'(1));
      tw_m1 = CW'(tw - SWW'(1));
      th_m1 = RW'(th - SHW'(1));
   end

   // source column/row from the integer part of the accumulators, clamped
   always_comb begin
      x_int = acc_x_ff[STEP_W-1:ACC_FRAC];
      y_int = acc_y_ff[STEP_W-1:ACC_FRAC];
      if (32'(x_int) > 32'(sw_m1)) begin
         col_sel = sw_m1;
      end else begin
         col_sel = CW'(x_int);
      end
      if (32'(y_int) > 32'(sh_m1)) begin
         up_sel = sh_m1;
      end else begin
         up_sel = RW'(y_int);
      end
      rend = 32'(dst_col_ff) >= 32'(tw_m1);
      fend = rend && (32'(dst_row_ff) >= 32'(th_m1));
   end

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_tvalid && req_tready;
   assign load_fire = req_fire && !req_tuser[0];
   assign emit_fire = req_fire && req_tuser[0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load_pix  = key_pixel(req_tdata, key_ff, mode_ff[MODE_KEY_EN]);

   // sequencer: next state and handshake
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tuser[0]) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // config and position registers; a csr write takes precedence
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff   <= SIZE_RESET;
         src_h_ff   <= SIZE_RESET;
         tgt_w_ff   <= SIZE_RESET;
         tgt_h_ff   <= SIZE_RESET;
         step_x_ff  <= STEP_RESET;
         step_y_ff  <= STEP_RESET;
         key_ff     <= '0;
         mode_ff    <= '0;
         ld_ptr_ff  <= '0;
         ld_col_ff  <= '0;
         ld_row_ff  <= '0;
         acc_x_ff   <= STEP_RESET >> 1;
         acc_y_ff   <= STEP_RESET >> 1;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: begin
               if (csr_index_type'(csr_index) == REG_SOURCE_WIDTH) begin
                  src_w_ff <= csr_data[SIZE_W-1:0];
               end else begin
                  src_h_ff <= csr_data[SIZE_W-1:0];
               end
               ld_ptr_ff <= '0;
               ld_col_ff <= '0;
               ld_row_ff <= '0;
            end
            REG_TARGET_WIDTH, REG_TARGET_HEIGHT: begin
               if (csr_index_type'(csr_index) == REG_TARGET_WIDTH) begin
                  tgt_w_ff <= csr_data[SIZE_W-1:0];
               end else begin
                  tgt_h_ff <= csr_data[SIZE_W-1:0];
               end
               dst_col_ff <= '0;
               dst_row_ff <= '0;
               acc_x_ff   <= step_x_ff >> 1;
               acc_y_ff   <= step_y_ff >> 1;
            end
            REG_STEP_X: begin
               step_x_ff  <= csr_data[STEP_W-1:0];
               dst_col_ff <= '0;
               dst_row_ff <= '0;
               acc_x_ff   <= csr_data[STEP_W-1:0] >> 1;
               acc_y_ff   <= step_y_ff >> 1;
            end
            REG_STEP_Y: begin
               step_y_ff  <= csr_data[STEP_W-1:0];
               dst_col_ff <= '0;
               dst_row_ff <= '0;
               acc_x_ff   <= step_x_ff >> 1;
               acc_y_ff   <= csr_data[STEP_W-1:0] >> 1;
            end
            REG_KEY_RGB: key_ff  <= csr_data[KEY_W-1:0];
            REG_MODE:    mode_ff <= csr_data[MODE_W-1:0];
            default: ;
         endcase
      end else if (load_fire) begin
         // raster walk over the source frame, wraps after the last pixel
         if (ld_col_ff == sw_m1) begin
            ld_col_ff <= '0;
            if (ld_row_ff == sh_m1) begin
               ld_row_ff <= '0;
               ld_ptr_ff <= '0;
            end else begin
               ld_row_ff <= ld_row_ff + RW'(1);
               ld_ptr_ff <= ld_ptr_ff + AW'(1);
            end
         end else begin
            ld_col_ff <= ld_col_ff + CW'(1);
            ld_ptr_ff <= ld_ptr_ff + AW'(1);
         end
      end else if (emit_fire) begin
         if (rend) begin
            dst_col_ff <= '0;
            acc_x_ff   <= step_x_ff >> 1;
            if (fend) begin
               dst_row_ff <= '0;
               acc_y_ff   <= step_y_ff >> 1;
            end else begin
               dst_row_ff <= dst_row_ff + RW'(1);
               acc_y_ff   <= sat_add(acc_y_ff, step_y_ff);
            end
         end else begin
            dst_col_ff <= dst_col_ff + CW'(1);
            acc_x_ff   <= sat_add(acc_x_ff, step_x_ff);
         end
      end
   end

   // emit payload: flipped row, then row * width + column
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         col_ff  <= col_sel;
         row_ff  <= sh_m1 - up_sel;
         rend_ff <= rend;
         fend_ff <= fend;
      end
      if (state_ff == ST_MUL) begin
         addr_ff <= AW'(row_ff) * AW'(sw) + AW'(col_ff);
      end
   end

   // frame store: one write port (loads), one registered read port (emits)
   always_ff @(posedge clock) begin
      if (load_fire) begin
         frame_mem[ld_ptr_ff] <= load_pix;
      end
      rd_data_ff <= frame_mem[addr_ff];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff  <= swizzle(rd_data_ff, mode_ff[MODE_BGRA], mode_ff[MODE_BIG]);
         rsp_last_ff  <= rend_ff;
         rsp_frame_ff <= fend_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_frame_ff;

   // checks
   `ASSERT_IMPL(a_frame_end_on_row_end, clock, reset, rsp_valid_ff && rsp_frame_ff, rsp_last_ff)
   `ASSERT_CLK(a_dest_col_in_range, clock, reset, 32'(dst_col_ff) <= 32'(tw_m1))
   `ASSERT_CLK(a_load_ptr_step, clock, reset, (load_fire && !csr_fire) |=> (ld_ptr_ff == '0 || ld_ptr_ff == AW'($past(ld_ptr_ff) + 1'b1)))
   `ASSERT_CLK(a_done_holds_on_stall, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE))

endmodule
